[design/ilist_pkg.sv]
// Shared types and constants for the indexed list block.
// Used by ilist_cell and indexed_list_insert_delete_top; depends on nothing.
package ilist_pkg;

   localparam int ACT_W   = 3;
   localparam int POS_W   = 10;
   localparam int DATA_W  = 32;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 7;

   typedef enum logic [ACT_W-1:0] {
      ACT_READ   = 3'd0,
      ACT_FRONT  = 3'd1,
      ACT_BACK   = 3'd2,
      ACT_AT     = 3'd3,
      ACT_DELETE = 3'd4
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE    = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } cell_op_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      cell_op_type              op;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

[design/ilist_cell.sv]
// One storage cell of the list row: holds the entry at a fixed position.
// Depends on ilist_pkg for the command struct and data width.
module ilist_cell
   import ilist_pkg::*;
#(
   parameter int Index = 0
) (
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic signed [DATA_W-1:0] left_value,
   input  logic signed [DATA_W-1:0] right_value,
   output logic signed [DATA_W-1:0] value,
   output logic signed [DATA_W-1:0] hit_value
);

   localparam logic [POS_W-1:0] MY_POS = POS_W'(Index);

   logic signed [DATA_W-1:0] value_ff, value_in;
   logic signed [DATA_W-1:0] hit_ff, hit_in;

   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         OP_INSERT: begin
            // Entries behind the insertion point move one place back.
            if (MY_POS > ctrl.pos) begin
               value_in = left_value;
            end else if (MY_POS == ctrl.pos) begin
               value_in = ctrl.value;
            end
         end
         OP_DELETE: begin
            // Entries from the deleted place on move one place forward.
            if (MY_POS >= ctrl.pos) begin
               value_in = right_value;
            end
         end
         default: value_in = value_ff;
      endcase
      hit_in = (MY_POS == ctrl.pos) ? value_ff : '0;
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      hit_ff   <= hit_in;
   end

   assign value     = value_ff;
   assign hit_value = hit_ff;

endmodule

[design/indexed_list_insert_delete_top.sv]
// Top level of the indexed list block: stream ports, command sequencer and
// the row of ilist_cell storage cells. Depends on ilist_pkg and ilist_cell.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit values in
// a row of cells, one cell per list position. Each request beat carries an
// action (read, insert at front, insert at back, insert before a position,
// delete at a position), a position and a value, and produces exactly one
// response beat with the read value, a status and the number of values held
// afterwards. Inserts and deletes shift every cell behind the affected place
// by one position together, each cell taking its neighbor's value.
// From acceptance to a valid response a request passes these steps in order:
// the beat is registered, the cell row executes the command while every
// cell registers its read candidate, and the candidates are combined into
// the response register. A new request is accepted only once the previous
// one has reached the response register, so requests are handled one at a
// time; a stalled response holds in its register and only the combining
// step waits for it. Reads at or past the count give -1 with status invalid,
// inserts past the count or into a full list and deletes past the count leave
// the list unchanged.
module indexed_list_insert_delete_top
   import ilist_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Request: [2:0] action, [12:3] position, [44:13] value, [47:45] zero.
   input  logic [47:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Response: [31:0] read_value, [33:32] status, [40:34] entry_count,
   // [47:41] zero.
   output logic [47:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_GATHER
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     use_hit_ff, use_hit_in;
   logic                     minus_one_ff, minus_one_in;
   status_type               status_ff, status_in;

   logic [ACT_W-1:0]         act_ff;
   logic [POS_W-1:0]         pos_ff;
   logic signed [DATA_W-1:0] val_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   status_type               rsp_status_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;

   cell_ctrl_type            ctrl;
   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic signed [DATA_W-1:0] cell_hit   [CAPACITY];
   logic signed [DATA_W-1:0] hit_or;

   logic req_fire;
   logic load_rsp;
   logic [CMP_W-1:0] pos_ext, cnt_ext;
   logic full;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign load_rsp   = (state_ff == S_GATHER) && (!rsp_valid_ff || rsp_tready);

   assign pos_ext = CMP_W'(pos_ff);
   assign cnt_ext = CMP_W'(count_ff);
   assign full    = (count_ff >= CNT_W'(CAPACITY));

   // Decode the registered request into a cell command and a status.
   always_comb begin
      ctrl.op      = OP_HOLD;
      ctrl.pos     = pos_ff;
      ctrl.value   = val_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      use_hit_in   = use_hit_ff;
      minus_one_in = minus_one_ff;
      if (state_ff == S_EXEC) begin
         status_in    = ST_DONE;
         use_hit_in   = 1'b0;
         minus_one_in = 1'b0;
         unique case (act_ff)
            ACT_READ: begin
               if (pos_ext < cnt_ext) begin
                  use_hit_in = 1'b1;
               end else begin
                  minus_one_in = 1'b1;
                  status_in    = ST_INVALID;
               end
            end
            ACT_FRONT, ACT_BACK, ACT_AT: begin
               if (act_ff == ACT_FRONT) begin
                  ctrl.pos = '0;
               end else if (act_ff == ACT_BACK) begin
                  ctrl.pos = POS_W'(count_ff);
               end
               if (act_ff == ACT_AT && pos_ext > cnt_ext) begin
                  status_in = ST_INVALID;
               end else if (full) begin
                  status_in = ST_FULL;
               end else begin
                  ctrl.op  = OP_INSERT;
                  count_in = count_ff + 1'b1;
               end
            end
            ACT_DELETE: begin
               if (pos_ext < cnt_ext) begin
                  ctrl.op  = OP_DELETE;
                  count_in = count_ff - 1'b1;
               end else begin
                  status_in = ST_INVALID;
               end
            end
            default: status_in = ST_INVALID;
         endcase
      end
   end

   // Sequencer: one request at a time through register, execute, gather.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: state_in = S_GATHER;
         S_GATHER: begin
            if (load_rsp) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         use_hit_ff   <= 1'b0;
         minus_one_ff <= 1'b0;
         status_ff    <= ST_DONE;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         use_hit_ff   <= use_hit_in;
         minus_one_ff <= minus_one_in;
         status_ff    <= status_in;
      end
   end

   // Payload registers: request fields and the response word.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff <= req_tdata[2:0];
         pos_ff <= req_tdata[12:3];
         val_ff <= req_tdata[44:13];
      end
      if (load_rsp) begin
         if (use_hit_ff) begin
            rsp_value_ff <= hit_or;
         end else if (minus_one_ff) begin
            rsp_value_ff <= '1;
         end else begin
            rsp_value_ff <= '0;
         end
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
      end
   end

   // The row of cells; each one sees its two neighbors.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_v, right_v;
      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = cell_value[i+1];
      end
      ilist_cell #(.Index(i)) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (cell_value[i]),
         .hit_value   (cell_hit[i])
      );
   end

   // At most one cell matches the position; the others present zero.
   always_comb begin
      hit_or = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         hit_or = hit_or | cell_hit[k];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_status_ff, rsp_value_ff};

endmodule
